// ----- hdl/tcw_pkg.sv -----
package tcw_pkg;

    localparam int COLS        = 80;
    localparam int ROWS        = 25;
    localparam int CELLS       = COLS * ROWS;
    localparam int SCROLL_END  = COLS * (ROWS - 1);
    localparam int ADDR_W      = $clog2(CELLS);
    localparam int COL_W       = $clog2(COLS + 1);
    localparam int LINE_W      = (ROWS > 2) ? $clog2(ROWS) : 1;
    localparam int CELL_W      = 16;
    localparam int CODE_W      = 8;
    localparam int OP_W        = 2;
    localparam int PC_W        = 5;

    localparam logic [CELL_W-1:0] ATTR_GREY    = 16'h0700;
    localparam logic [CODE_W-1:0] NEWLINE_CODE = 8'd10;

    localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    // microprogram step addresses
    localparam logic [PC_W-1:0] S_BOOT    = 5'd0;
    localparam logic [PC_W-1:0] S_BWIPE   = 5'd1;
    localparam logic [PC_W-1:0] S_BEXIT   = 5'd2;
    localparam logic [PC_W-1:0] S_CLR     = 5'd3;
    localparam logic [PC_W-1:0] S_CWIPE   = 5'd4;
    localparam logic [PC_W-1:0] S_DONE    = 5'd5;
    localparam logic [PC_W-1:0] S_IDLE    = 5'd6;
    localparam logic [PC_W-1:0] S_DISP_C  = 5'd7;
    localparam logic [PC_W-1:0] S_DISP_R  = 5'd8;
    localparam logic [PC_W-1:0] S_DISP_P  = 5'd9;
    localparam logic [PC_W-1:0] S_WRAP    = 5'd10;
    localparam logic [PC_W-1:0] S_PUT_NL  = 5'd11;
    localparam logic [PC_W-1:0] S_PUT_WR  = 5'd12;
    localparam logic [PC_W-1:0] S_LF      = 5'd13;
    localparam logic [PC_W-1:0] S_LF_DOWN = 5'd14;
    localparam logic [PC_W-1:0] S_SC_RD   = 5'd15;
    localparam logic [PC_W-1:0] S_SC_WR   = 5'd16;
    localparam logic [PC_W-1:0] S_SC_BL   = 5'd17;
    localparam logic [PC_W-1:0] S_LF_RET  = 5'd18;
    localparam logic [PC_W-1:0] S_LF_EXIT = 5'd19;
    localparam logic [PC_W-1:0] S_READ    = 5'd20;
    localparam logic [PC_W-1:0] S_RD_CAP  = 5'd21;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_ACCEPT,
        C_OP_CLEAR,
        C_OP_READ,
        C_OP_OTHER,
        C_COL_FULL,
        C_CODE_NL,
        C_LINE_LAST,
        C_PTR_MORE_CELLS,
        C_PTR_MORE_SCROLL,
        C_RET,
        C_OUT_BUSY
    } cond_t;

    typedef enum logic [1:0] {PTR_HOLD, PTR_ZERO, PTR_INC} ptr_act_t;
    typedef enum logic [1:0] {WR_NONE, WR_ZERO, WR_CHAR, WR_RDATA} wr_sel_t;
    typedef enum logic [1:0] {RD_NONE, RD_SCROLL, RD_ADDR} rd_sel_t;
    typedef enum logic [1:0] {COL_HOLD, COL_INC, COL_ZERO} col_act_t;
    typedef enum logic [1:0] {RET_HOLD, RET_SET, RET_CLR} ret_act_t;

    typedef struct packed {
        cond_t             cond;
        logic [PC_W-1:0]   target;
        ptr_act_t          ptr_act;
        wr_sel_t           wr_sel;
        rd_sel_t           rd_sel;
        col_act_t          col_act;
        logic              line_inc;
        ret_act_t          ret_act;
        logic              out_load;
        logic              in_ready;
        logic              value_cap;
    } ctrl_t;

    typedef struct packed {
        logic accept;
        logic op_clear;
        logic op_read;
        logic op_other;
        logic col_full;
        logic code_nl;
        logic line_last;
        logic ptr_more_cells;
        logic ptr_more_scroll;
        logic ret;
        logic out_busy;
    } flags_t;

    function automatic ctrl_t rom_word(input logic [PC_W-1:0] pc);
        ctrl_t c;
        c = '0;
        case (pc)
            S_BOOT:    c.ptr_act = PTR_ZERO;
            S_BWIPE:
            begin
                c.wr_sel  = WR_ZERO;
                c.ptr_act = PTR_INC;
                c.cond    = C_PTR_MORE_CELLS;
                c.target  = S_BWIPE;
            end
            S_BEXIT:
            begin
                c.cond   = C_ALWAYS;
                c.target = S_IDLE;
            end
            S_CLR:     c.ptr_act = PTR_ZERO;
            S_CWIPE:
            begin
                c.wr_sel  = WR_ZERO;
                c.ptr_act = PTR_INC;
                c.cond    = C_PTR_MORE_CELLS;
                c.target  = S_CWIPE;
            end
            S_DONE:
            begin
                c.out_load = 1'b1;
                c.cond     = C_OUT_BUSY;
                c.target   = S_DONE;
            end
            S_IDLE:
            begin
                c.in_ready = 1'b1;
                c.cond     = C_NO_ACCEPT;
                c.target   = S_IDLE;
            end
            S_DISP_C:
            begin
                c.cond   = C_OP_CLEAR;
                c.target = S_CLR;
            end
            S_DISP_R:
            begin
                c.cond   = C_OP_READ;
                c.target = S_READ;
            end
            S_DISP_P:
            begin
                c.cond   = C_OP_OTHER;
                c.target = S_DONE;
            end
            S_WRAP:
            begin
                c.ret_act = RET_SET;
                c.cond    = C_COL_FULL;
                c.target  = S_LF;
            end
            S_PUT_NL:
            begin
                c.ret_act = RET_CLR;
                c.cond    = C_CODE_NL;
                c.target  = S_LF;
            end
            S_PUT_WR:
            begin
                c.wr_sel  = WR_CHAR;
                c.col_act = COL_INC;
                c.cond    = C_ALWAYS;
                c.target  = S_DONE;
            end
            S_LF:
            begin
                c.ptr_act = PTR_ZERO;
                c.cond    = C_LINE_LAST;
                c.target  = S_SC_RD;
            end
            S_LF_DOWN:
            begin
                c.line_inc = 1'b1;
                c.cond     = C_ALWAYS;
                c.target   = S_LF_RET;
            end
            S_SC_RD:   c.rd_sel = RD_SCROLL;
            S_SC_WR:
            begin
                c.wr_sel  = WR_RDATA;
                c.ptr_act = PTR_INC;
                c.cond    = C_PTR_MORE_SCROLL;
                c.target  = S_SC_RD;
            end
            S_SC_BL:
            begin
                c.wr_sel  = WR_ZERO;
                c.ptr_act = PTR_INC;
                c.cond    = C_PTR_MORE_CELLS;
                c.target  = S_SC_BL;
            end
            S_LF_RET:
            begin
                c.col_act = COL_ZERO;
                c.cond    = C_RET;
                c.target  = S_PUT_NL;
            end
            S_LF_EXIT:
            begin
                c.cond   = C_ALWAYS;
                c.target = S_DONE;
            end
            S_READ:    c.rd_sel = RD_ADDR;
            S_RD_CAP:
            begin
                c.value_cap = 1'b1;
                c.cond      = C_ALWAYS;
                c.target    = S_DONE;
            end
            default:
            begin
                c.cond   = C_ALWAYS;
                c.target = S_IDLE;
            end
        endcase
        return c;
    endfunction

endpackage

// ----- hdl/text_console_writer_unit.sv -----
// Text console writer: 80 x 25 screen of 16-bit cells with a cursor.
// Input stream (s_axis): one request per handshake. tuser carries the
// operation (put character, clear screen, read one cell), tdata the
// character byte and the cell address, tlast the end of one write call.
// Output stream (m_axis): exactly one result per request, in order:
// cell value (reads only, else zero), cursor column and row after the
// request, and tlast echoing the request's tlast.
// Timing is set by a microcoded sequencer over a single-port-write,
// single-port-read screen memory; a new request is taken only once the
// previous one has finished. A character on a full row first wraps to a
// new line, and a newline byte there feeds two lines. A scroll copies
// each cell below the top row one row up (a read, then a write) and then
// blanks the bottom row; a clear writes zero to every cell. After reset
// the memory is swept to zero before the first request is accepted. A
// finished result waits in the output register; while m_axis_tready is
// low the next request is still accepted and run, and its result is held
// back until the output register frees up.
module text_console_writer_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // char_code[7:0], cell_address[18:8]
    input  logic [1:0]  s_axis_tuser,   // operation[1:0]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // cell_value[15:0], cursor_column[22:16],
                                        // cursor_row[27:23]
    output logic        m_axis_tlast
);

    tcw_pkg::ctrl_t  ctrl;
    tcw_pkg::flags_t flags;

    logic [tcw_pkg::OP_W-1:0]   op_reg;
    logic [tcw_pkg::CODE_W-1:0] code_reg;
    logic [tcw_pkg::ADDR_W-1:0] addr_reg;
    logic                       last_reg;
    logic                       addr_ok;

    logic [tcw_pkg::COL_W-1:0]  col_reg;
    logic [tcw_pkg::LINE_W-1:0] line_reg;
    logic [tcw_pkg::ADDR_W-1:0] ptr_reg;
    logic                       ret_reg;
    logic [tcw_pkg::CELL_W-1:0] value_reg;

    logic                       out_valid_reg;
    logic [tcw_pkg::CELL_W-1:0] out_value_reg;
    logic [tcw_pkg::COL_W-1:0]  out_col_reg;
    logic [tcw_pkg::LINE_W-1:0] out_line_reg;
    logic                       out_last_reg;

    logic                       accept;
    logic                       out_busy;
    logic                       out_load;
    logic [tcw_pkg::ADDR_W-1:0] cur_idx;

    logic                       mem_we;
    logic [tcw_pkg::ADDR_W-1:0] mem_waddr;
    logic [tcw_pkg::CELL_W-1:0] mem_wdata;
    logic                       mem_re;
    logic [tcw_pkg::ADDR_W-1:0] mem_raddr;
    logic [tcw_pkg::CELL_W-1:0] mem_rdata;

    assign s_axis_tready = ctrl.in_ready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_busy      = out_valid_reg && !m_axis_tready;
    assign out_load      = ctrl.out_load && !out_busy;
    assign addr_ok       = addr_reg < tcw_pkg::ADDR_W'(tcw_pkg::CELLS);
    assign cur_idx       = tcw_pkg::ADDR_W'(line_reg * tcw_pkg::COLS)
                         + tcw_pkg::ADDR_W'(col_reg);

    always_comb
    begin
        flags.accept          = accept;
        flags.op_clear        = op_reg == tcw_pkg::OP_CLEAR;
        flags.op_read         = op_reg == tcw_pkg::OP_READ;
        flags.op_other        = op_reg != tcw_pkg::OP_PUT;
        flags.col_full        = col_reg >= tcw_pkg::COL_W'(tcw_pkg::COLS);
        flags.code_nl         = code_reg == tcw_pkg::NEWLINE_CODE;
        flags.line_last       = line_reg >= tcw_pkg::LINE_W'(tcw_pkg::ROWS - 1);
        flags.ptr_more_cells  = ptr_reg != tcw_pkg::ADDR_W'(tcw_pkg::CELLS - 1);
        flags.ptr_more_scroll = ptr_reg != tcw_pkg::ADDR_W'(tcw_pkg::SCROLL_END - 1);
        flags.ret             = ret_reg;
        flags.out_busy        = out_busy;
    end

    tcw_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = ptr_reg;
        mem_wdata = '0;
        case (ctrl.wr_sel)
            tcw_pkg::WR_ZERO:
            begin
                mem_we = 1'b1;
            end
            tcw_pkg::WR_CHAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = cur_idx;
                mem_wdata = tcw_pkg::ATTR_GREY | tcw_pkg::CELL_W'(code_reg);
            end
            tcw_pkg::WR_RDATA:
            begin
                mem_we    = 1'b1;
                mem_wdata = mem_rdata;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase

        mem_re    = 1'b0;
        mem_raddr = ptr_reg + tcw_pkg::ADDR_W'(tcw_pkg::COLS);
        case (ctrl.rd_sel)
            tcw_pkg::RD_SCROLL:
            begin
                mem_re = 1'b1;
            end
            tcw_pkg::RD_ADDR:
            begin
                mem_re    = addr_ok;
                mem_raddr = addr_reg;
            end
            default:
            begin
                mem_re = 1'b0;
            end
        endcase
    end

    tcw_ram #(
        .DEPTH (tcw_pkg::CELLS),
        .WIDTH (tcw_pkg::CELL_W)
    ) u_screen (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // request fields and read value
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= s_axis_tuser;
            code_reg  <= s_axis_tdata[7:0];
            addr_reg  <= s_axis_tdata[18:8];
            last_reg  <= s_axis_tlast;
            value_reg <= '0;
        end
        else if (ctrl.value_cap)
        begin
            value_reg <= addr_ok ? mem_rdata : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            line_reg <= '0;
            ptr_reg  <= '0;
            ret_reg  <= 1'b0;
        end
        else
        begin
            case (ctrl.ptr_act)
                tcw_pkg::PTR_ZERO: ptr_reg <= '0;
                tcw_pkg::PTR_INC:  ptr_reg <= ptr_reg + 1'b1;
                default:           ptr_reg <= ptr_reg;
            endcase
            case (ctrl.col_act)
                tcw_pkg::COL_INC:  col_reg <= col_reg + 1'b1;
                tcw_pkg::COL_ZERO: col_reg <= '0;
                default:           col_reg <= col_reg;
            endcase
            case (ctrl.ret_act)
                tcw_pkg::RET_SET: ret_reg <= 1'b1;
                tcw_pkg::RET_CLR: ret_reg <= 1'b0;
                default:          ret_reg <= ret_reg;
            endcase
            if (ctrl.line_inc)
            begin
                line_reg <= line_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_value_reg <= value_reg;
            out_col_reg   <= col_reg;
            out_line_reg  <= line_reg;
            out_last_reg  <= last_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0, out_line_reg, out_col_reg, out_value_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

// ----- hdl/tcw_ram.sv -----
module tcw_ram #(
    parameter int DEPTH = 2000,
    parameter int WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hdl/tcw_seq.sv -----
module tcw_seq (
    input  logic           clk,
    input  logic           rst_n,
    input  tcw_pkg::flags_t flags,
    output tcw_pkg::ctrl_t  ctrl
);

    logic [tcw_pkg::PC_W-1:0] pc_reg;
    logic [tcw_pkg::PC_W-1:0] pc_next;
    logic                     take;

    assign ctrl = tcw_pkg::rom_word(pc_reg);

    always_comb
    begin
        case (ctrl.cond)
            tcw_pkg::C_NEVER:           take = 1'b0;
            tcw_pkg::C_ALWAYS:          take = 1'b1;
            tcw_pkg::C_NO_ACCEPT:       take = !flags.accept;
            tcw_pkg::C_OP_CLEAR:        take = flags.op_clear;
            tcw_pkg::C_OP_READ:         take = flags.op_read;
            tcw_pkg::C_OP_OTHER:        take = flags.op_other;
            tcw_pkg::C_COL_FULL:        take = flags.col_full;
            tcw_pkg::C_CODE_NL:         take = flags.code_nl;
            tcw_pkg::C_LINE_LAST:       take = flags.line_last;
            tcw_pkg::C_PTR_MORE_CELLS:  take = flags.ptr_more_cells;
            tcw_pkg::C_PTR_MORE_SCROLL: take = flags.ptr_more_scroll;
            tcw_pkg::C_RET:             take = flags.ret;
            tcw_pkg::C_OUT_BUSY:        take = flags.out_busy;
            default:                    take = 1'b0;
        endcase
        pc_next = take ? ctrl.target : pc_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= tcw_pkg::S_BOOT;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

// ----- verif/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [tcw_pkg::OP_W-1:0] OP_NOP = 2'd3;
    localparam int unsigned REQUEST_TARGET = 700;
    localparam int unsigned CYCLE_LIMIT    = 2_000_000;
    localparam int unsigned DRAIN_CYCLES   = 4000;
    localparam int unsigned HOLD_CYCLES    = 6000;
    localparam int unsigned TDATA_PAD      = 24 - tcw_pkg::ADDR_W - tcw_pkg::CODE_W;

    typedef struct packed {
        logic [tcw_pkg::OP_W-1:0]   op;
        logic [tcw_pkg::CODE_W-1:0] code;
        logic [tcw_pkg::ADDR_W-1:0] addr;
        logic                       last;
    } console_req_t;

    typedef struct packed {
        logic [tcw_pkg::CELL_W-1:0] cell_val;
        logic [tcw_pkg::COL_W-1:0]  col;
        logic [tcw_pkg::LINE_W-1:0] row;
        logic                       done;
    } console_view_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;     // char_code[7:0], cell_address[18:8]
    logic [1:0]  s_axis_tuser = '0;     // operation[1:0]
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;          // cell_value[15:0], cursor_column[22:16],
                                        // cursor_row[27:23]
    logic        m_axis_tlast;

    console_req_t  request_backlog [$];
    console_view_t expected_views [$];
    console_req_t  next_req;
    console_view_t want;
    int unsigned   requests_total;
    int unsigned   work_requests;
    int unsigned   requests_taken = 0;
    int unsigned   results_seen = 0;
    int unsigned   failures = 0;
    int unsigned   cycles = 0;
    int unsigned   hold_left = 0;
    logic          hold_armed = 1'b1;

    // shadow of the screen and cursor
    logic [tcw_pkg::CELL_W-1:0] shadow_screen [tcw_pkg::CELLS];
    logic [tcw_pkg::COL_W-1:0]  shadow_col;
    logic [tcw_pkg::LINE_W-1:0] shadow_row;

    text_console_writer_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic void shadow_line_feed();
        if (shadow_row >= tcw_pkg::ROWS - 1)
        begin
            for (int k = 0; k < tcw_pkg::SCROLL_END; k++)
                shadow_screen[k] = shadow_screen[k + tcw_pkg::COLS];
            for (int k = tcw_pkg::SCROLL_END; k < tcw_pkg::CELLS; k++)
                shadow_screen[k] = '0;
        end
        else
            shadow_row = shadow_row + 1'b1;
        shadow_col = '0;
    endfunction

    function automatic console_view_t console_apply(console_req_t r);
        console_view_t v;
        int            idx;
        v = '0;
        case (r.op)
            tcw_pkg::OP_PUT:
            begin
                if (shadow_col >= tcw_pkg::COLS)
                    shadow_line_feed();
                if (r.code == tcw_pkg::NEWLINE_CODE)
                    shadow_line_feed();
                else
                begin
                    idx = int'(shadow_row) * tcw_pkg::COLS + int'(shadow_col);
                    shadow_screen[idx] = tcw_pkg::ATTR_GREY
                        | {{(tcw_pkg::CELL_W-tcw_pkg::CODE_W){1'b0}}, r.code};
                    shadow_col = shadow_col + 1'b1;
                end
            end
            tcw_pkg::OP_CLEAR:
                for (int k = 0; k < tcw_pkg::CELLS; k++)
                    shadow_screen[k] = '0;
            tcw_pkg::OP_READ:
                if (r.addr < tcw_pkg::CELLS)
                    v.cell_val = shadow_screen[r.addr];
            default: ;
        endcase
        v.col  = shadow_col;
        v.row  = shadow_row;
        v.done = r.last;
        return v;
    endfunction

    task automatic push_request(logic [tcw_pkg::OP_W-1:0] op,
                                logic [tcw_pkg::CODE_W-1:0] code,
                                logic [tcw_pkg::ADDR_W-1:0] addr, logic last);
        console_req_t r;
        r.op   = op;
        r.code = code;
        r.addr = addr;
        r.last = last;
        request_backlog.push_back(r);
        if (op != OP_NOP)
            work_requests++;
    endtask

    function automatic logic [tcw_pkg::CODE_W-1:0] text_byte();
        logic [tcw_pkg::CODE_W-1:0] c;
        c = tcw_pkg::CODE_W'($urandom_range(255));
        if (c == tcw_pkg::NEWLINE_CODE)
            c = c + 1'b1;
        return c;
    endfunction

    // noise: mostly the unused opcode, sometimes any opcode
    function automatic logic [tcw_pkg::OP_W-1:0] OP_ARGS_NOISE_OP();
        return ($urandom_range(3) != 0) ? OP_NOP : tcw_pkg::OP_W'($urandom_range(3));
    endfunction

    initial
    begin
        int unsigned pick;
        int unsigned len;
        logic [tcw_pkg::CODE_W-1:0] code;
        logic [tcw_pkg::ADDR_W-1:0] addr;

        for (int k = 0; k < tcw_pkg::CELLS; k++)
            shadow_screen[k] = '0;
        shadow_col = '0;
        shadow_row = '0;
        work_requests = 0;

        // directed: field extremes, every operation, corner cases
        push_request(tcw_pkg::OP_READ,  8'h00, 11'd0,    1'b0);
        push_request(tcw_pkg::OP_READ,  8'hFF, 11'd1999, 1'b1);
        push_request(tcw_pkg::OP_READ,  8'h00, 11'd2000, 1'b0);
        push_request(tcw_pkg::OP_READ,  8'h00, 11'h7FF,  1'b1);
        push_request(tcw_pkg::OP_PUT,   8'h00, 11'h7FF,  1'b0);
        push_request(tcw_pkg::OP_PUT,   8'hFF, 11'd0,    1'b1);
        push_request(tcw_pkg::OP_PUT,   8'h41, 11'd0,    1'b0);
        push_request(tcw_pkg::OP_READ,  8'h00, 11'd0,    1'b0);
        push_request(tcw_pkg::OP_READ,  8'h00, 11'd1,    1'b1);
        push_request(tcw_pkg::OP_READ,  8'h00, 11'd2,    1'b0);
        push_request(tcw_pkg::OP_PUT,   tcw_pkg::NEWLINE_CODE, 11'd0, 1'b1);
        push_request(tcw_pkg::OP_PUT,   8'h0B, 11'd0,    1'b1);
        push_request(tcw_pkg::OP_READ,  8'h00, 11'd80,   1'b0);
        push_request(OP_NOP,            8'hFF, 11'h7FF,  1'b1);
        push_request(OP_NOP,            8'h00, 11'd0,    1'b0);
        push_request(tcw_pkg::OP_CLEAR, 8'hFF, 11'h7FF,  1'b1);
        push_request(tcw_pkg::OP_READ,  8'h00, 11'd1,    1'b0);
        push_request(tcw_pkg::OP_PUT,   8'h55, 11'h2AA,  1'b0);
        push_request(tcw_pkg::OP_PUT,   8'hAA, 11'h555,  1'b1);
        push_request(tcw_pkg::OP_READ,  8'h00, 11'd81,   1'b0);
        push_request(tcw_pkg::OP_READ,  8'h00, 11'h555,  1'b1);
        push_request(tcw_pkg::OP_READ,  8'h00, 11'h2AA,  1'b0);

        // move the cursor down with newline bytes mixed among text bytes
        for (int k = 0; k < 26; k++)
            push_request(tcw_pkg::OP_PUT,
                         (k % 3 == 0) ? text_byte() : tcw_pkg::NEWLINE_CODE,
                         tcw_pkg::ADDR_W'($urandom_range(2047)), k[0]);

        while (work_requests < REQUEST_TARGET)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
            begin
                // one write call
                len = $urandom_range(12, 1);
                for (int k = 0; k < len; k++)
                begin
                    code = ($urandom_range(99) < 8) ? tcw_pkg::NEWLINE_CODE
                                                    : tcw_pkg::CODE_W'($urandom_range(255));
                    push_request(tcw_pkg::OP_PUT, code,
                                 tcw_pkg::ADDR_W'($urandom_range(2047)),
                                 (k == len - 1) ? 1'b1 : ($urandom_range(99) < 10));
                end
            end
            else if (pick < 75)
            begin
                len = $urandom_range(4, 1);
                for (int k = 0; k < len; k++)
                begin
                    pick = $urandom_range(3);
                    if (pick == 0)
                        addr = tcw_pkg::ADDR_W'($urandom_range(2047));
                    else if (pick == 1)
                        addr = tcw_pkg::ADDR_W'($urandom_range(tcw_pkg::CELLS - 1,
                                                                tcw_pkg::SCROLL_END));
                    else
                        addr = tcw_pkg::ADDR_W'($urandom_range(tcw_pkg::CELLS - 1));
                    push_request(tcw_pkg::OP_READ, tcw_pkg::CODE_W'($urandom_range(255)),
                                 addr, 1'($urandom_range(1)));
                end
            end
            else if (pick < 78)
            begin
                // full row, then wrap by a character or by a newline byte
                push_request(tcw_pkg::OP_PUT, tcw_pkg::NEWLINE_CODE, '0, 1'b0);
                for (int k = 0; k < tcw_pkg::COLS; k++)
                    push_request(tcw_pkg::OP_PUT, text_byte(),
                                 tcw_pkg::ADDR_W'($urandom_range(2047)), 1'b0);
                push_request(tcw_pkg::OP_PUT,
                             $urandom_range(1) ? tcw_pkg::NEWLINE_CODE : text_byte(),
                             '0, 1'b1);
                push_request(tcw_pkg::OP_READ, '0,
                             tcw_pkg::ADDR_W'($urandom_range(tcw_pkg::CELLS - 1,
                                              tcw_pkg::SCROLL_END - tcw_pkg::COLS)),
                             1'b0);
            end
            else if (pick < 82)
                push_request(tcw_pkg::OP_CLEAR, tcw_pkg::CODE_W'($urandom_range(255)),
                             tcw_pkg::ADDR_W'($urandom_range(2047)), 1'($urandom_range(1)));
            else if (pick < 90)
                push_request(OP_ARGS_NOISE_OP(), tcw_pkg::CODE_W'($urandom_range(255)),
                             tcw_pkg::ADDR_W'($urandom_range(2047)), 1'($urandom_range(1)));
            else
            begin
                len = $urandom_range(3, 1);
                for (int k = 0; k < len; k++)
                    push_request(tcw_pkg::OP_PUT, tcw_pkg::NEWLINE_CODE,
                                 tcw_pkg::ADDR_W'($urandom_range(2047)), (k == len - 1));
            end
        end
        requests_total = request_backlog.size();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (requests_taken < requests_total)
            @(posedge clk);
        while (expected_views.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // request driver
    always @(posedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (request_backlog.size() != 0 &&
                ((requests_taken >= 300 && requests_taken < 450) || $urandom_range(99) >= 8))
            begin
                next_req = request_backlog.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {{TDATA_PAD{1'b0}}, next_req.addr, next_req.code};
                s_axis_tuser  <= next_req.op;
                s_axis_tlast  <= next_req.last;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // accepted requests feed the shadow model
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            expected_views.push_back(console_apply('{
                op:   s_axis_tuser,
                code: s_axis_tdata[tcw_pkg::CODE_W-1:0],
                addr: s_axis_tdata[tcw_pkg::CODE_W+tcw_pkg::ADDR_W-1:tcw_pkg::CODE_W],
                last: s_axis_tlast}));
            requests_taken <= requests_taken + 1;
        end
    end

    // long receiver hold-off to back the block up
    always @(posedge clk)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (hold_armed && results_seen >= 150)
        begin
            hold_left  <= HOLD_CYCLES;
            hold_armed <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= (hold_left == 0) &&
                ((results_seen >= 300 && results_seen < 450) || $urandom_range(99) >= 8);
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen <= results_seen + 1;
            if (expected_views.size() == 0)
            begin
                $error("result with no request outstanding: tdata %h tlast %b",
                       m_axis_tdata, m_axis_tlast);
                failures++;
            end
            else
            begin
                want = expected_views.pop_front();
                if (m_axis_tdata[tcw_pkg::CELL_W-1:0] !== want.cell_val)
                begin
                    $error("cell_value: expected %h, got %h",
                           want.cell_val, m_axis_tdata[tcw_pkg::CELL_W-1:0]);
                    failures++;
                end
                if (m_axis_tdata[tcw_pkg::CELL_W+tcw_pkg::COL_W-1:tcw_pkg::CELL_W]
                    !== want.col)
                begin
                    $error("cursor_column: expected %0d, got %0d", want.col,
                           m_axis_tdata[tcw_pkg::CELL_W+tcw_pkg::COL_W-1:tcw_pkg::CELL_W]);
                    failures++;
                end
                if (m_axis_tdata[tcw_pkg::CELL_W+tcw_pkg::COL_W+tcw_pkg::LINE_W-1:
                                 tcw_pkg::CELL_W+tcw_pkg::COL_W] !== want.row)
                begin
                    $error("cursor_row: expected %0d, got %0d", want.row,
                           m_axis_tdata[tcw_pkg::CELL_W+tcw_pkg::COL_W+tcw_pkg::LINE_W-1:
                                        tcw_pkg::CELL_W+tcw_pkg::COL_W]);
                    failures++;
                end
                if (m_axis_tlast !== want.done)
                begin
                    $error("write_done: expected %b, got %b", want.done, m_axis_tlast);
                    failures++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

endmodule
